[sv/emb_pkg.sv]
// Shared types and constants for the embedding table training engine.
// Used by emb_ctrl, emb_dpath, emb_sqrt, emb_div and the top level.
`default_nettype none

package emb_pkg;

    // Parameter defaults
    localparam int VOCAB_DEF = 1024;
    localparam int DIM_DEF   = 64;

    // Fixed field widths
    localparam int NV_W   = 17;   // holds an effective row count up to 65536
    localparam int COL_W  = 6;
    localparam int GRAD_W = 24;
    localparam int NUM_W  = 56;   // clip numerator: 24x32 product plus rounding
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;

    // Function codes
    typedef enum logic [2:0] {
        FN_LOOKUP = 3'd0,
        FN_ACCUM  = 3'd1,
        FN_WRITE  = 3'd2,
        FN_UPDATE = 3'd3,
        FN_ZERO   = 3'd4,
        FN_CLIP   = 3'd5,
        FN_NORM   = 3'd6
    } t_func;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_VOCAB = 2'd0,
        CFG_DIM   = 2'd1,
        CFG_LRATE = 2'd2,
        CFG_CLIP  = 2'd3
    } t_cfg_idx;

    // Kind of result loaded into the output register
    typedef enum logic [1:0] {
        K_OK,
        K_BAD,
        K_LOOK,
        K_NORM
    } t_kind;

    // Memory address source
    typedef enum logic [1:0] {
        A_CNT,
        A_IN,
        A_CLR
    } t_asel;

    // Controller to datapath
    typedef struct packed {
        logic  cap_in;
        logic  cnt_clr;
        logic  t_from_tok;
        logic  cnt_step;
        logic  rd;
        logic  acc_wr;
        logic  wt_wr;
        logic  upd_mul;
        logic  upd_wr;
        logic  zero_wr;
        logic  clr_wr;
        logic  sq_mul;
        logic  sq_acc;
        logic  sum_clr;
        logic  sq_start;
        logic  cl_mul;
        logic  dv_start;
        logic  clip_wr;
        logic  out_load;
        t_kind kind;
        t_asel asel;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       bad;
        logic       col_ok;
        logic       c_last;
        logic       t_last;
        logic       nv_zero;
        logic       out_free;
        logic       clr_last;
        logic       sq_busy;
        logic       dv_busy;
        logic       clip_need;
    } t_sts;

endpackage

`default_nettype wire

[sv/emb_sqrt.sv]
// Iterative integer square root, one result bit per cycle (floor).
// Depends on emb_pkg for widths.
`default_nettype none

module emb_sqrt (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [emb_pkg::SUM_W-1:0]       i_x,
    output logic                                 o_busy,
    output logic [emb_pkg::ROOT_W-1:0]           o_root
);

    localparam int RW = emb_pkg::ROOT_W + 4;
    localparam int CW = $clog2(emb_pkg::ROOT_W);

    logic [emb_pkg::SUM_W-1:0]  r_x;
    logic [RW-1:0]              r_rem;
    logic [emb_pkg::ROOT_W-1:0] r_root;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          take;

    // Bring down two bits, try subtracting 4*root+1
    always_comb begin
        rem_sh = {r_rem[RW-3:0], r_x[emb_pkg::SUM_W-1 -: 2]};
        trial  = RW'({r_root, 2'b01});
        take   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[emb_pkg::SUM_W-3:0], 2'b00};
            r_rem  <= take ? rem_sh - trial : rem_sh;
            r_root <= {r_root[emb_pkg::ROOT_W-2:0], take};
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == CW'(emb_pkg::ROOT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

[sv/emb_div.sv]
// Restoring divider for gradient clipping, one quotient bit per cycle.
// Depends on emb_pkg for widths; returns the low gradient-width quotient bits.
`default_nettype none

module emb_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [emb_pkg::NUM_W-1:0]      i_num,
    input  wire logic [emb_pkg::ROOT_W-1:0]     i_den,
    output logic                                o_busy,
    output logic [emb_pkg::GRAD_W-1:0]          o_quo
);

    localparam int DW = emb_pkg::ROOT_W;
    localparam int CW = $clog2(emb_pkg::NUM_W);

    logic [emb_pkg::NUM_W-1:0]  r_num;
    logic [DW-1:0]              r_den;
    logic [DW-1:0]              r_rem;
    logic [emb_pkg::GRAD_W-1:0] r_quo;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;

    logic [DW:0] rem_sh;
    logic        take;

    // Shift in one numerator bit and compare with the divisor
    always_comb begin
        rem_sh = {r_rem, r_num[emb_pkg::NUM_W-1]};
        take   = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[emb_pkg::NUM_W-2:0], 1'b0};
            r_rem <= take ? DW'(rem_sh - {1'b0, r_den}) : DW'(rem_sh);
            r_quo <= {r_quo[emb_pkg::GRAD_W-2:0], take};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(emb_pkg::NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

[sv/emb_ctrl.sv]
// Controller state machine: sequences lookup runs, table sweeps and results.
// Depends on emb_pkg for the command and status structs.
`default_nettype none

module emb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire emb_pkg::t_sts i_sts,
    output emb_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_RES,
        S_LK_RD, S_LK_OUT,
        S_AC_RD, S_AC_WR,
        S_UP_RD, S_UP_MUL, S_UP_WR,
        S_ZR,
        S_NM_RD, S_NM_SQ, S_NM_ACC,
        S_SQ_GO, S_SQ_WAIT,
        S_CL_RD, S_CL_MUL, S_CL_DIV, S_CL_WAIT
    } t_state;

    t_state         r_state, n_state;
    emb_pkg::t_kind r_kind, n_kind;
    emb_pkg::t_cmd  cmd;
    logic           sweep_last;

    assign sweep_last = i_sts.c_last & i_sts.t_last;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        cmd     = '0;
        cmd.kind = r_kind;
        cmd.asel = emb_pkg::A_CNT;
        unique case (r_state)
            S_CLR: begin
                cmd.clr_wr = 1'b1;
                cmd.asel   = emb_pkg::A_CLR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap_in = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_kind  = emb_pkg::K_OK;
                n_state = S_RES;
                if (i_sts.bad && i_sts.func <= emb_pkg::FN_WRITE) begin
                    n_kind = emb_pkg::K_BAD;
                end else begin
                    case (i_sts.func)
                        emb_pkg::FN_LOOKUP: begin
                            cmd.cnt_clr    = 1'b1;
                            cmd.t_from_tok = 1'b1;
                            n_state        = S_LK_RD;
                        end
                        emb_pkg::FN_ACCUM: begin
                            if (i_sts.col_ok) n_state = S_AC_RD;
                        end
                        emb_pkg::FN_WRITE: begin
                            cmd.asel  = emb_pkg::A_IN;
                            cmd.wt_wr = i_sts.col_ok;
                        end
                        emb_pkg::FN_UPDATE: begin
                            cmd.cnt_clr = 1'b1;
                            if (!i_sts.nv_zero) n_state = S_UP_RD;
                        end
                        emb_pkg::FN_ZERO: begin
                            cmd.cnt_clr = 1'b1;
                            if (!i_sts.nv_zero) n_state = S_ZR;
                        end
                        emb_pkg::FN_CLIP, emb_pkg::FN_NORM: begin
                            cmd.cnt_clr = 1'b1;
                            cmd.sum_clr = 1'b1;
                            n_state     = i_sts.nv_zero ? S_SQ_GO : S_NM_RD;
                        end
                        default: n_state = S_RES;
                    endcase
                end
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            // Lookup run, one element per output transfer
            S_LK_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_LK_OUT;
            end
            S_LK_OUT: begin
                cmd.kind = emb_pkg::K_LOOK;
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (i_sts.c_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.cnt_step = 1'b1;
                        n_state      = S_LK_RD;
                    end
                end
            end
            // Accumulate: read, add, write back
            S_AC_RD: begin
                cmd.rd   = 1'b1;
                cmd.asel = emb_pkg::A_IN;
                n_state  = S_AC_WR;
            end
            S_AC_WR: begin
                cmd.acc_wr = 1'b1;
                cmd.asel   = emb_pkg::A_IN;
                n_state    = S_RES;
            end
            // SGD sweep
            S_UP_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_UP_MUL;
            end
            S_UP_MUL: begin
                cmd.upd_mul = 1'b1;
                n_state     = S_UP_WR;
            end
            S_UP_WR: begin
                cmd.upd_wr = 1'b1;
                if (sweep_last) begin
                    n_state = S_RES;
                end else begin
                    cmd.cnt_step = 1'b1;
                    n_state      = S_UP_RD;
                end
            end
            // Gradient clear sweep
            S_ZR: begin
                cmd.zero_wr = 1'b1;
                if (sweep_last) begin
                    n_state = S_RES;
                end else begin
                    cmd.cnt_step = 1'b1;
                end
            end
            // Sum of squares sweep
            S_NM_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_NM_SQ;
            end
            S_NM_SQ: begin
                cmd.sq_mul = 1'b1;
                n_state    = S_NM_ACC;
            end
            S_NM_ACC: begin
                cmd.sq_acc = 1'b1;
                if (sweep_last) begin
                    n_state = S_SQ_GO;
                end else begin
                    cmd.cnt_step = 1'b1;
                    n_state      = S_NM_RD;
                end
            end
            S_SQ_GO: begin
                cmd.sq_start = 1'b1;
                n_state      = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (!i_sts.sq_busy) begin
                    if (i_sts.clip_need) begin
                        cmd.cnt_clr = 1'b1;
                        n_state     = S_CL_RD;
                    end else begin
                        n_kind  = emb_pkg::K_NORM;
                        n_state = S_RES;
                    end
                end
            end
            // Clip sweep: multiply, divide, write back
            S_CL_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_CL_MUL;
            end
            S_CL_MUL: begin
                cmd.cl_mul = 1'b1;
                n_state    = S_CL_DIV;
            end
            S_CL_DIV: begin
                cmd.dv_start = 1'b1;
                n_state      = S_CL_WAIT;
            end
            S_CL_WAIT: begin
                if (!i_sts.dv_busy) begin
                    cmd.clip_wr = 1'b1;
                    if (sweep_last) begin
                        n_kind  = emb_pkg::K_NORM;
                        n_state = S_RES;
                    end else begin
                        cmd.cnt_step = 1'b1;
                        n_state      = S_CL_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_kind  <= emb_pkg::K_OK;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

[sv/emb_dpath.sv]
// Datapath: config registers, weight and gradient memories, arithmetic,
// sweep counters and the output register. Uses emb_pkg, emb_sqrt, emb_div.
`default_nettype none

module emb_dpath #(
    parameter int VOCAB = emb_pkg::VOCAB_DEF,
    parameter int DIM   = emb_pkg::DIM_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire emb_pkg::t_cmd        i_cmd,
    output emb_pkg::t_sts             o_sts,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    // input payload
    input  wire logic [2:0]           i_func,
    input  wire logic [9:0]           i_token,
    input  wire logic [5:0]           i_col,
    input  wire logic signed [15:0]   i_value,
    // output channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_status,
    output logic signed [15:0]        o_element,
    output logic [5:0]                o_element_index,
    output logic [31:0]               o_grad_norm,
    output logic                      o_was_clipped,
    output logic                      o_last
);

    localparam int DEPTH = VOCAB * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(VOCAB);
    localparam int NVW   = emb_pkg::NV_W;
    localparam int GW    = emb_pkg::GRAD_W;
    localparam logic [AW-1:0] DIM_A  = AW'(DIM);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

    // Configuration registers
    logic [10:0] r_vlim;
    logic [6:0]  r_dim;
    logic [15:0] r_lr;
    logic [31:0] r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlim <= 11'd1024;
            r_dim  <= 7'd64;
            r_lr   <= 16'd655;
            r_clip <= 32'd2048;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                emb_pkg::CFG_VOCAB: r_vlim <= i_cfg_data[10:0];
                emb_pkg::CFG_DIM:   r_dim  <= i_cfg_data[6:0];
                emb_pkg::CFG_LRATE: r_lr   <= i_cfg_data[15:0];
                emb_pkg::CFG_CLIP:  r_clip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured input item
    logic [2:0]         r_func;
    logic [9:0]         r_tok;
    logic [5:0]         r_col;
    logic signed [15:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_func <= i_func;
            r_tok  <= i_token;
            r_col  <= i_col;
            r_val  <= i_value;
        end
    end

    // Effective row and column counts
    logic [NVW-1:0] nv;
    logic [6:0]     nd_min, nd;

    always_comb begin
        nv     = (NVW'(r_vlim) < NVW'(VOCAB)) ? NVW'(r_vlim) : NVW'(VOCAB);
        nd_min = (r_dim < 7'(DIM)) ? r_dim : 7'(DIM);
        nd     = (nd_min == 7'd0) ? 7'd1 : nd_min;
    end

    // Sweep counters and clearing-pass counter
    logic [TW-1:0]  r_t;
    logic [5:0]     r_c;
    logic [AW-1:0]  r_clr;
    logic           c_last, t_last;

    assign c_last = ({1'b0, r_c} == nd - 7'd1);
    assign t_last = (NVW'(r_t) == nv - NVW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_c <= '0;
            r_t <= i_cmd.t_from_tok ? TW'(r_tok) : '0;
        end else if (i_cmd.cnt_step) begin
            if (c_last) begin
                r_c <= '0;
                r_t <= r_t + 1'b1;
            end else begin
                r_c <= r_c + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Address select
    logic [AW-1:0] addr;

    always_comb begin
        unique case (i_cmd.asel)
            emb_pkg::A_IN:  addr = AW'(r_tok) * DIM_A + AW'(r_col);
            emb_pkg::A_CLR: addr = r_clr;
            default:        addr = AW'(r_t) * DIM_A + AW'(r_c);
        endcase
    end

    // Memories with registered read data
    logic signed [15:0]   wmem [DEPTH];
    logic signed [GW-1:0] gmem [DEPTH];
    logic signed [15:0]   r_wq;
    logic signed [GW-1:0] r_gq;
    logic                 w_we, g_we;
    logic signed [15:0]   w_wd;
    logic signed [GW-1:0] g_wd;

    always_ff @(posedge i_clk) begin
        if (w_we) wmem[addr] <= w_wd;
        if (i_cmd.rd) r_wq <= wmem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) gmem[addr] <= g_wd;
        if (i_cmd.rd) r_gq <= gmem[addr];
    end

    // Saturating accumulate
    logic signed [GW:0]   acc_sum;
    logic signed [GW-1:0] acc_sat;

    always_comb begin
        acc_sum = {r_gq[GW-1], r_gq} + (GW+1)'(r_val);
        if (acc_sum[GW] != acc_sum[GW-1]) begin
            acc_sat = acc_sum[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[GW-1:0];
        end
    end

    // SGD step: product registered, then round and saturate
    logic signed [40:0] upd_p, r_prod;
    logic [40:0]        upd_mag;
    logic [24:0]        upd_d;
    logic signed [26:0] upd_diff;
    logic signed [15:0] upd_w;

    assign upd_p = $signed({1'b0, r_lr}) * r_gq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_mul) r_prod <= upd_p;
    end

    always_comb begin
        upd_mag = r_prod[40] ? 41'(-r_prod) : r_prod;
        upd_d   = 25'((upd_mag + 41'd32768) >> 16);
        if (r_prod[40]) begin
            upd_diff = 27'(r_wq) + $signed({2'b00, upd_d});
        end else begin
            upd_diff = 27'(r_wq) - $signed({2'b00, upd_d});
        end
        if (upd_diff > 27'sd32767) begin
            upd_w = 16'sh7FFF;
        end else if (upd_diff < -27'sd32768) begin
            upd_w = -16'sh8000;
        end else begin
            upd_w = upd_diff[15:0];
        end
    end

    // Sum of squares
    logic signed [47:0] sq_full;
    logic [47:0]        r_sq;
    logic [emb_pkg::SUM_W-1:0] r_sum;

    assign sq_full = r_gq * r_gq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_mul) r_sq <= sq_full;
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sq_acc) begin
            r_sum <= r_sum + emb_pkg::SUM_W'(r_sq);
        end
    end

    // Square root unit
    logic                       sq_busy;
    logic [emb_pkg::ROOT_W-1:0] nrm;

    emb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_x     (r_sum),
        .o_busy  (sq_busy),
        .o_root  (nrm)
    );

    // Clip scaling: |g| * limit, then divide by the norm with rounding
    logic [GW-1:0]              cl_mag;
    logic [emb_pkg::NUM_W-1:0]  cl_prod, r_cp;
    logic [emb_pkg::NUM_W-1:0]  dv_num;
    logic                       dv_busy;
    logic [GW-1:0]              dv_quo;
    logic signed [GW-1:0]       clip_val;

    always_comb begin
        cl_mag   = r_gq[GW-1] ? GW'(-r_gq) : r_gq;
        cl_prod  = emb_pkg::NUM_W'(cl_mag) * emb_pkg::NUM_W'(r_clip);
        dv_num   = r_cp + emb_pkg::NUM_W'(nrm >> 1);
        clip_val = r_gq[GW-1] ? GW'(-dv_quo) : dv_quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cl_mul) r_cp <= cl_prod;
    end

    emb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.dv_start),
        .i_num   (dv_num),
        .i_den   (nrm),
        .o_busy  (dv_busy),
        .o_quo   (dv_quo)
    );

    // Memory write ports
    always_comb begin
        w_we = i_cmd.wt_wr | i_cmd.upd_wr;
        w_wd = i_cmd.wt_wr ? r_val : upd_w;
        g_we = i_cmd.acc_wr | i_cmd.upd_wr | i_cmd.zero_wr | i_cmd.clr_wr
             | i_cmd.clip_wr;
        priority if (i_cmd.acc_wr) begin
            g_wd = acc_sat;
        end else if (i_cmd.clip_wr) begin
            g_wd = clip_val;
        end else begin
            g_wd = '0;
        end
    end

    // Output register
    logic r_o_valid;
    logic out_free;
    logic clip_need;

    assign out_free  = !r_o_valid || !i_out_stall;
    assign clip_need = (r_func == emb_pkg::FN_CLIP) && (nrm > r_clip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status        <= 1'b0;
            o_element       <= '0;
            o_element_index <= '0;
            o_grad_norm     <= '0;
            o_was_clipped   <= 1'b0;
            o_last          <= 1'b1;
            unique case (i_cmd.kind)
                emb_pkg::K_BAD: o_status <= 1'b1;
                emb_pkg::K_LOOK: begin
                    o_element       <= r_wq;
                    o_element_index <= r_c;
                    o_last          <= c_last;
                end
                emb_pkg::K_NORM: begin
                    o_grad_norm   <= nrm;
                    o_was_clipped <= clip_need;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_o_valid;

    // Status back to the controller
    always_comb begin
        o_sts           = '0;
        o_sts.func      = r_func;
        o_sts.bad       = NVW'(r_tok) >= nv;
        o_sts.col_ok    = {1'b0, r_col} < nd;
        o_sts.c_last    = c_last;
        o_sts.t_last    = t_last;
        o_sts.nv_zero   = (nv == '0);
        o_sts.out_free  = out_free;
        o_sts.clr_last  = (r_clr == LAST_A);
        o_sts.sq_busy   = sq_busy;
        o_sts.dv_busy   = dv_busy;
        o_sts.clip_need = clip_need;
    end

endmodule

`default_nettype wire

[sv/embedding_table_train_engine_top.sv]
// Top level of the embedding table training engine.
// Instantiates emb_ctrl and emb_dpath; types from emb_pkg.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_func i_token i_col i_value
//  out     | output    | o_out_valid / i_out_stall  | o_status o_element o_element_index
//          |           |                            | o_grad_norm o_was_clipped o_last
//  cfg     | input     | i_cfg_we                   | i_cfg_index i_cfg_data
//
// One item at a time. Lookup reads and outputs each element in turn; accumulate reads,
// then writes back. Update reads, multiplies and writes each element over the rows and
// columns in use, zero writes each, norm reads, squares and sums each before the
// bit-serial root; if the norm exceeds the limit, clip also multiplies and runs the
// 56-step divider per element. After reset a clearing pass writes all gradient memory
// with o_in_stall high. Output stalls hold the controller until the transfer goes.
`default_nettype none

module embedding_table_train_engine_top #(
    parameter int VOCAB = emb_pkg::VOCAB_DEF,
    parameter int DIM   = emb_pkg::DIM_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_func,
    input  wire logic [9:0]         i_token,
    input  wire logic [5:0]         i_col,
    input  wire logic signed [15:0] i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_status,
    output logic signed [15:0]      o_element,
    output logic [5:0]              o_element_index,
    output logic [31:0]             o_grad_norm,
    output logic                    o_was_clipped,
    output logic                    o_last,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    emb_pkg::t_cmd cmd;
    emb_pkg::t_sts sts;

    emb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    emb_dpath #(
        .VOCAB (VOCAB),
        .DIM   (DIM)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_token         (i_token),
        .i_col           (i_col),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_element       (o_element),
        .o_element_index (o_element_index),
        .o_grad_norm     (o_grad_norm),
        .o_was_clipped   (o_was_clipped),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
